// ----- sv/rgbw_pixel_fade_engine_macros.svh -----
// ----------------------------------------------------------------------------
// RGBW pixel fade engine assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RGBW_PIXEL_FADE_ENGINE_MACROS_SVH
`define RGBW_PIXEL_FADE_ENGINE_MACROS_SVH

// same-cycle implication
`define RGBWF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbwf checker: property failed");

// next-cycle implication
`define RGBWF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbwf checker: property failed");

`endif

// ----- sv/rgbwf_pkg.sv -----
// ----------------------------------------------------------------------------
// RGBW pixel fade package
// Types, widths and defaults shared by the fade engine and its step lanes.
// ----------------------------------------------------------------------------
package rgbwf_pkg;

   localparam int IDX_W      = 7;
   localparam int CH_W       = 8;
   localparam int DIFF_W     = CH_W + 1;
   localparam int FACTOR_W   = 6;
   localparam int PROD_W     = FACTOR_W + 1 + DIFF_W;
   localparam int DIV_IN_W   = 14;
   localparam int RECIP_W    = DIV_IN_W + 1;
   localparam int PIXELS_DEF = 128;
   localparam int STEPS_DEF  = 37;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef logic [3:0][CH_W-1:0]   rgbw_type;
   typedef logic [3:0][DIFF_W-1:0] diff4_type;

   typedef struct packed {
      rgbw_type  cur;
      rgbw_type  snap;
      diff4_type diff;
   } pixel_state_type;

   typedef struct packed {
      logic                load;
      logic [FACTOR_W-1:0] factor;
   } step_ctrl_type;

endpackage

// ----- sv/rgbwf_lane.sv -----
// ----------------------------------------------------------------------------
// RGBW fade step lane
// One channel: difference, factor product, exact divide by STEPS through a
// reciprocal multiply, and the new current value. Two register stages.
// ----------------------------------------------------------------------------
module rgbwf_lane
   import rgbwf_pkg::*;
#(
   parameter int STEPS = STEPS_DEF
) (
   input  logic                     clock,
   input  step_ctrl_type            ctrl,
   input  logic [CH_W-1:0]          cur_in,
   input  logic [CH_W-1:0]          tgt_in,
   input  logic [CH_W-1:0]          snap_in,
   input  logic signed [DIFF_W-1:0] diff_in,
   output logic [CH_W-1:0]          cur_out,
   output logic [CH_W-1:0]          snap_out,
   output logic signed [DIFF_W-1:0] diff_out
);

   localparam int RecipShift = DIV_IN_W + $clog2(STEPS);
   localparam longint unsigned RecipFull =
      ((64'd1 << RecipShift) + 64'(STEPS) - 64'd1) / 64'(STEPS);
   localparam logic [RECIP_W-1:0] RecipMul = RECIP_W'(RecipFull);
   localparam int ScaledW = DIV_IN_W + RECIP_W;

   logic signed [DIFF_W-1:0] diff_sel;
   logic [CH_W-1:0]          snap_sel;
   logic signed [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0]        mag_full;
   logic [ScaledW-1:0]       scaled_in;
   logic [CH_W-1:0]          quot;

   logic signed [PROD_W-1:0] prod_s1_ff;
   logic signed [DIFF_W-1:0] diff_s1_ff;
   logic [CH_W-1:0]          snap_s1_ff;
   logic [ScaledW-1:0]       scaled_s2_ff;
   logic                     neg_s2_ff;
   logic signed [DIFF_W-1:0] diff_s2_ff;
   logic [CH_W-1:0]          snap_s2_ff;

   always_comb begin
      if (ctrl.load) begin
         diff_sel = $signed({1'b0, cur_in}) - $signed({1'b0, tgt_in});
         snap_sel = tgt_in;
      end else begin
         diff_sel = diff_in;
         snap_sel = snap_in;
      end
      prod_in = $signed({1'b0, ctrl.factor}) * diff_sel;
   end

   always_comb begin
      mag_full  = prod_s1_ff[PROD_W-1] ? PROD_W'(-prod_s1_ff) : PROD_W'(prod_s1_ff);
      scaled_in = ScaledW'(mag_full[DIV_IN_W-1:0]) * ScaledW'(RecipMul);
   end

   always_ff @(posedge clock) begin
      prod_s1_ff   <= prod_in;
      diff_s1_ff   <= diff_sel;
      snap_s1_ff   <= snap_sel;
      scaled_s2_ff <= scaled_in;
      neg_s2_ff    <= prod_s1_ff[PROD_W-1];
      diff_s2_ff   <= diff_s1_ff;
      snap_s2_ff   <= snap_s1_ff;
   end

   assign quot     = CH_W'(scaled_s2_ff >> RecipShift);
   assign cur_out  = neg_s2_ff ? (snap_s2_ff - quot) : (snap_s2_ff + quot);
   assign snap_out = snap_s2_ff;
   assign diff_out = diff_s2_ff;

endmodule

// ----- sv/rgbw_pixel_fade_engine.sv -----
// ----------------------------------------------------------------------------
// RGBW pixel fade engine
// Current and target RGBW values per pixel with a linear crossfade stepper.
// ----------------------------------------------------------------------------
// Each command yields one result strobe of one cycle; the receiver cannot
// stall, so sample rsp_* whenever rsp_strobe is high. After reset the engine
// clears both pixel memories, holding busy high until the clear is done. A
// write, or a tick while no fade runs, is answered in the next cycle; a read
// is answered after the ST_READ state. A start, or a tick during a fade,
// sweeps every pixel entry through the read-modify-write pipeline, one pixel
// per cycle with all four channels in parallel. The next command waits for
// the sweep to drain, set by the single read port of the pixel state memory
// and the read-modify-write path (memory read plus two step lane stages).
// ----------------------------------------------------------------------------
module rgbw_pixel_fade_engine
   import rgbwf_pkg::*;
#(
   parameter int PIXELS = PIXELS_DEF,
   parameter int STEPS  = STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_opcode,
   input  logic [IDX_W-1:0] req_pixel_index,
   input  logic [CH_W-1:0]  req_red_in,
   input  logic [CH_W-1:0]  req_green_in,
   input  logic [CH_W-1:0]  req_blue_in,
   input  logic [CH_W-1:0]  req_white_in,
   output logic             rsp_strobe,
   output logic [CH_W-1:0]  rsp_red_out,
   output logic [CH_W-1:0]  rsp_green_out,
   output logic [CH_W-1:0]  rsp_blue_out,
   output logic [CH_W-1:0]  rsp_white_out,
   output logic             rsp_fading,
   output logic             rsp_fade_done
);

   localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam logic [AW-1:0] LastAddr = AW'(PIXELS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   pixel_state_type state_mem [PIXELS];
   rgbw_type        tgt_mem   [PIXELS];

   pixel_state_type state_q_ff;
   rgbw_type        tgt_q_ff;

   state_type           state_ff, state_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic                load_ff, load_in;
   logic                active_ff, active_in;
   logic                rd_ok_ff, rd_ok_in;
   logic                v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]       a1_ff, a2_ff, a3_ff;
   logic                strobe_ff, strobe_in;
   rgbw_type            colors_ff, colors_in;
   logic                fading_ff, fading_in;
   logic                done_ff, done_in;

   logic            accept;
   logic            in_range;
   logic [AW-1:0]   req_addr;
   logic [AW-1:0]   rd_addr;
   step_ctrl_type   ctrl;
   pixel_state_type wb_data;
   logic            state_we;
   logic [AW-1:0]   state_wa;
   pixel_state_type state_wd;
   logic            tgt_we;
   logic [AW-1:0]   tgt_wa;
   rgbw_type        tgt_wd;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = (32'(req_pixel_index) < 32'(PIXELS));
   assign req_addr = AW'(req_pixel_index);
   assign rd_addr  = (state_ff == ST_IDLE) ? req_addr : cnt_ff;

   assign ctrl.load   = load_ff;
   assign ctrl.factor = factor_ff;

   for (genvar ch = 0; ch < 4; ch++) begin : g_lane
      rgbwf_lane #(
         .STEPS(STEPS)
      ) u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .cur_in  (state_q_ff.cur[ch]),
         .tgt_in  (tgt_q_ff[ch]),
         .snap_in (state_q_ff.snap[ch]),
         .diff_in (state_q_ff.diff[ch]),
         .cur_out (wb_data.cur[ch]),
         .snap_out(wb_data.snap[ch]),
         .diff_out(wb_data.diff[ch])
      );
   end

   always_comb begin
      state_we = 1'b0;
      state_wa = a3_ff;
      state_wd = wb_data;
      tgt_we   = 1'b0;
      tgt_wa   = req_addr;
      tgt_wd   = {req_white_in, req_blue_in, req_green_in, req_red_in};
      if (state_ff == ST_CLEAR) begin
         state_we = 1'b1;
         state_wa = cnt_ff;
         state_wd = '0;
         tgt_we   = 1'b1;
         tgt_wa   = cnt_ff;
         tgt_wd   = '0;
      end else begin
         state_we = v3_ff;
         tgt_we   = accept && (opcode_type'(req_opcode) == OP_WRITE) && in_range;
      end
   end

   always_ff @(posedge clock) begin
      state_q_ff <= state_mem[rd_addr];
      if (state_we) begin
         state_mem[state_wa] <= state_wd;
      end
   end

   always_ff @(posedge clock) begin
      tgt_q_ff <= tgt_mem[rd_addr];
      if (tgt_we) begin
         tgt_mem[tgt_wa] <= tgt_wd;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      factor_in = factor_ff;
      load_in   = load_ff;
      active_in = active_ff;
      rd_ok_in  = rd_ok_ff;
      strobe_in = 1'b0;
      colors_in = '0;
      fading_in = active_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastAddr) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (opcode_type'(req_opcode))
                  OP_WRITE: begin
                     strobe_in = 1'b1;
                  end
                  OP_START: begin
                     factor_in = FACTOR_W'(STEPS - 1);
                     load_in   = 1'b1;
                     active_in = (STEPS > 1);
                     cnt_in    = '0;
                     state_in  = ST_SWEEP;
                  end
                  OP_TICK: begin
                     if (active_ff) begin
                        factor_in = factor_ff - 1'b1;
                        load_in   = 1'b0;
                        active_in = (factor_ff != FACTOR_W'(1));
                        cnt_in    = '0;
                        state_in  = ST_SWEEP;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     rd_ok_in = in_range;
                     state_in = ST_READ;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            strobe_in = 1'b1;
            colors_in = rd_ok_ff ? state_q_ff.cur : '0;
            state_in  = ST_IDLE;
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastAddr) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (v3_ff && !v2_ff && !v1_ff) begin
               strobe_in = 1'b1;
               done_in   = (factor_ff == '0);
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cnt_ff    <= '0;
         factor_ff <= '0;
         load_ff   <= 1'b0;
         active_ff <= 1'b0;
         rd_ok_ff  <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         strobe_ff <= 1'b0;
         fading_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         factor_ff <= factor_in;
         load_ff   <= load_in;
         active_ff <= active_in;
         rd_ok_ff  <= rd_ok_in;
         v1_ff     <= (state_ff == ST_SWEEP);
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         strobe_ff <= strobe_in;
         fading_ff <= fading_in;
         done_ff   <= done_in;
      end
      a1_ff     <= cnt_ff;
      a2_ff     <= a1_ff;
      a3_ff     <= a2_ff;
      colors_ff <= colors_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_red_out   = colors_ff[0];
   assign rsp_green_out = colors_ff[1];
   assign rsp_blue_out  = colors_ff[2];
   assign rsp_white_out = colors_ff[3];
   assign rsp_fading    = fading_ff;
   assign rsp_fade_done = done_ff;

endmodule

// ----- sv/rgbwf_checker.sv -----
// ----------------------------------------------------------------------------
// RGBW pixel fade checker
// Port-level properties of the fade engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgbw_pixel_fade_engine_macros.svh"

module rgbwf_checker
   import rgbwf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [1:0]       req_opcode,
   input logic             rsp_strobe,
   input logic [CH_W-1:0]  rsp_red_out,
   input logic [CH_W-1:0]  rsp_green_out,
   input logic [CH_W-1:0]  rsp_blue_out,
   input logic [CH_W-1:0]  rsp_white_out,
   input logic             rsp_fading,
   input logic             rsp_fade_done
);

   logic accept;
   logic colors_zero;

   assign accept      = start && !busy;
   assign colors_zero = (rsp_red_out == '0) && (rsp_green_out == '0) &&
                        (rsp_blue_out == '0) && (rsp_white_out == '0);

   // a finished fade is never reported as still running
   `RGBWF_ASSERT_IMP(a_done_not_fading, clock, reset, rsp_strobe && rsp_fade_done, !rsp_fading)
   // fade completion comes from a sweep, which carries no colors
   `RGBWF_ASSERT_IMP(a_done_no_colors, clock, reset, rsp_strobe && rsp_fade_done, colors_zero)
   // a target write transfer is answered in the next cycle
   `RGBWF_ASSERT_NXT(a_write_resp, clock, reset, accept && (req_opcode == OP_WRITE), rsp_strobe)
   // a start sweeps every pixel, so busy holds and no answer comes at once
   `RGBWF_ASSERT_NXT(a_start_busy, clock, reset, accept && (req_opcode == OP_START), busy && !rsp_strobe)

endmodule

bind rgbw_pixel_fade_engine rgbwf_checker u_rgbwf_checker (.*);
